/* design/cll_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cll_pkg
// Shared constants, types and helpers of the cursor linked list engine.
// ----------------------------------------------------------------------------
package cll_pkg;

    // Number of record slots and the widths that follow from it.
    localparam int SLOTS  = 64;
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Links are seven bits wide; all ones marks the end of the list.
    localparam int              LINK_W    = 7;
    localparam logic [LINK_W-1:0] NULL_LINK = 7'h7F;

    // Field widths of one word on either side.
    localparam int IDX_W  = 6;
    localparam int NUM_W  = 32;
    localparam int NA_W   = 64;
    localparam int NB_W   = 64;
    localparam int NC_W   = 32;
    localparam int REC_W  = NUM_W + NA_W + NB_W + NC_W;
    localparam int FLD_W  = IDX_W + REC_W;
    localparam int DATA_W = ((FLD_W + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - FLD_W;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_INSERT   = 2'd1,
        CMD_TRAVERSE = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNALLOC = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // A link names a live slot when it lies below the allocation count.
    function automatic logic is_live(input logic [LINK_W-1:0] link,
                                     input logic [CNT_W-1:0]  used);
        return link < LINK_W'(used);
    endfunction

endpackage : cll_pkg
`default_nettype wire

/* design/cursor_linked_list_engine_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top
// Array-backed singly linked list of member records with append, insert-after
// and traverse commands.
// ----------------------------------------------------------------------------
// The engine keeps up to SLOTS records (a signed 32-bit member number and a
// 20-byte name) in a record RAM and their next-links in a link RAM; slots are
// handed out in order and never reused. One command word is taken at a time,
// and s_tready stays low until the command has finished its work. Append walks
// the list from the head through the link RAM read port, one link per cycle,
// to find the tail. Traverse emits one result word per record in list order,
// one per cycle while m_tready is high, and marks the final word with m_tlast;
// an empty list gives a single word with status list-empty. Every command
// other than the unused code gives exactly one result word, or the records in
// the case of traverse, and the last word always carries m_tlast. Results sit
// in an output register, so a new command is taken while the previous answer
// still waits on m_tready. There is no clearing pass: only slots already
// written are ever read.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Command side.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // From bit 0: slot_index[6], member_number[32], name_part_a[64],
    // name_part_b[64], name_part_c[32], zero padding.
    input  wire logic [cll_pkg::DATA_W-1:0] s_tdata,
    // cmd[2].
    input  wire logic [1:0]                s_tuser,
    // Result side.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // From bit 0: record_slot[6], record_number[32], record_name_a[64],
    // record_name_b[64], record_name_c[32], zero padding.
    output logic      [cll_pkg::DATA_W-1:0] m_tdata,
    // status[2].
    output logic      [1:0]                m_tuser,
    output logic                           m_tlast
);

    import cll_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FETCH    = 8'b0000_0010,
        S_WALK     = 8'b0000_0100,
        S_TAIL     = 8'b0000_1000,
        S_INS_CHK  = 8'b0001_0000,
        S_INS_LINK = 8'b0010_0000,
        S_TRAV     = 8'b0100_0000,
        S_REPLY    = 8'b1000_0000
    } state_t;

    // Control state.
    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   used_reg,    used_next;
    logic [LINK_W-1:0]  head_reg,    head_next;
    logic               out_valid_reg, out_valid_next;

    // Working and payload registers.
    cmd_t               cmd_reg,     cmd_next;
    logic [AW-1:0]      p_reg,       p_next;
    logic [CNT_W-1:0]   step_reg,    step_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic [IDX_W-1:0]   rsp_slot_reg,   rsp_slot_next;
    status_t            out_status_reg, out_status_next;
    logic               out_last_reg,   out_last_next;
    logic [DATA_W-1:0]  out_data_reg,   out_data_next;

    // RAM ports.
    logic               rec_we;
    logic [AW-1:0]      rec_waddr;
    logic [REC_W-1:0]   rec_wdata;
    logic [REC_W-1:0]   rec_rdata;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [LINK_W-1:0]  link_wdata;
    logic [LINK_W-1:0]  link_rdata;
    logic [AW-1:0]      rd_addr;

    // Decoded command word.
    cmd_t               in_cmd;
    logic [IDX_W-1:0]   in_idx;
    logic               accept;
    logic               full;
    logic               idx_live;
    logic               out_free;
    logic               walk_more;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_idx    = s_tdata[IDX_W-1:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (used_reg == CNT_W'(SLOTS));
    assign idx_live  = (LINK_W'(in_idx) < LINK_W'(used_reg));
    assign out_free  = !out_valid_reg || m_tready;
    // The walk goes on while the step budget lasts and the next link is live.
    assign walk_more = (step_reg != CNT_W'(SLOTS)) && is_live(link_rdata, used_reg);

    // A new record is written the moment its command is taken.
    assign rec_waddr = used_reg[AW-1:0];
    assign rec_wdata = s_tdata[FLD_W-1:IDX_W];

    cll_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_wdata),
        .rd_addr (rd_addr),
        .rd_data (rec_rdata)
    );

    cll_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (rd_addr),
        .rd_data (link_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        head_next       = head_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cmd_next        = cmd_reg;
        p_next          = p_reg;
        step_next       = step_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;
        rec_we          = 1'b0;
        link_we         = 1'b0;
        link_waddr      = p_reg;
        link_wdata      = NULL_LINK;
        rd_addr         = p_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = in_cmd;
                    step_next = CNT_W'(1);
                    case (in_cmd)
                        CMD_APPEND, CMD_INSERT:
                        begin
                            if (full)
                            begin
                                rsp_status_next = ST_FULL;
                                rsp_slot_next   = '0;
                                state_next      = S_REPLY;
                            end
                            else if ((in_cmd == CMD_INSERT) && !idx_live)
                            begin
                                rsp_status_next = ST_UNALLOC;
                                rsp_slot_next   = in_idx;
                                state_next      = S_REPLY;
                            end
                            else
                            begin
                                rec_we = 1'b1;
                                if (in_cmd == CMD_INSERT)
                                begin
                                    p_next     = in_idx[AW-1:0];
                                    state_next = S_FETCH;
                                end
                                else if (!is_live(head_reg, used_reg))
                                begin
                                    // Empty list: the new slot becomes the head.
                                    head_next  = LINK_W'(used_reg);
                                    state_next = S_TAIL;
                                end
                                else
                                begin
                                    p_next     = head_reg[AW-1:0];
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        CMD_TRAVERSE:
                        begin
                            if (!is_live(head_reg, used_reg))
                            begin
                                rsp_status_next = ST_EMPTY;
                                rsp_slot_next   = '0;
                                state_next      = S_REPLY;
                            end
                            else
                            begin
                                p_next     = head_reg[AW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                // The read of slot p is under way; its data shows next cycle.
                case (cmd_reg)
                    CMD_APPEND:   state_next = S_WALK;
                    CMD_INSERT:   state_next = S_INS_CHK;
                    default:      state_next = S_TRAV;
                endcase
            end

            S_WALK:
            begin
                if (walk_more)
                begin
                    p_next    = link_rdata[AW-1:0];
                    rd_addr   = link_rdata[AW-1:0];
                    step_next = step_reg + CNT_W'(1);
                end
                else
                begin
                    // Tail found: hang the new slot behind it.
                    link_we    = 1'b1;
                    link_waddr = p_reg;
                    link_wdata = LINK_W'(used_reg);
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                link_we         = 1'b1;
                link_waddr      = used_reg[AW-1:0];
                link_wdata      = NULL_LINK;
                used_next       = used_reg + CNT_W'(1);
                rsp_status_next = ST_OK;
                rsp_slot_next   = IDX_W'(used_reg);
                state_next      = S_REPLY;
            end

            S_INS_CHK:
            begin
                // The new slot inherits the successor of slot p.
                link_we    = 1'b1;
                link_waddr = used_reg[AW-1:0];
                link_wdata = link_rdata;
                state_next = S_INS_LINK;
            end

            S_INS_LINK:
            begin
                link_we         = 1'b1;
                link_waddr      = p_reg;
                link_wdata      = LINK_W'(used_reg);
                used_next       = used_reg + CNT_W'(1);
                rsp_status_next = ST_OK;
                rsp_slot_next   = IDX_W'(used_reg);
                state_next      = S_REPLY;
            end

            S_TRAV:
            begin
                // While the output is blocked the read address stays on p,
                // so both RAMs keep presenting the same record.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_last_next   = !walk_more;
                    out_data_next   = {{PAD_W{1'b0}}, rec_rdata, IDX_W'(p_reg)};
                    if (walk_more)
                    begin
                        p_next    = link_rdata[AW-1:0];
                        rd_addr   = link_rdata[AW-1:0];
                        step_next = step_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rsp_status_reg;
                    out_last_next   = 1'b1;
                    out_data_next   = {{(DATA_W-IDX_W){1'b0}}, rsp_slot_reg};
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            head_reg      <= NULL_LINK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        p_reg          <= p_next;
        step_reg       <= step_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule : cursor_linked_list_engine_top
`default_nettype wire

/* design/cll_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cll_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : cll_ram
`default_nettype wire

/* tb/cursor_linked_list_engine_top_tb.sv */
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top_tb
// Self-checking testbench for the cursor linked list engine.
// ----------------------------------------------------------------------------
// Command words go in on the slave stream. A behavioral copy of the record
// store, the links, the head and the allocation count turns every accepted
// command into the result words the engine must produce. Those words are
// queued, and each word taken from the master stream is compared field by
// field with the oldest one. Both streams idle at random. One test holds the
// result side off for a long stretch so that the engine stalls its input.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cll_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_TICKS = 7;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 2 * SLOTS + 20;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_CMDS = 295;

    // Bit offsets of the record fields inside tdata, from bit 0 up.
    localparam int NUM_LO = IDX_W;
    localparam int NA_LO  = NUM_LO + NUM_W;
    localparam int NB_LO  = NA_LO + NA_W;
    localparam int NC_LO  = NB_LO + NB_W;

    typedef struct {
        status_t               status;
        logic [IDX_W-1:0]      slot;
        logic [NUM_W-1:0]      number;
        logic [NA_W-1:0]       name_a;
        logic [NB_W-1:0]       name_b;
        logic [NC_W-1:0]       name_c;
        logic                  last;
    } result_word_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [1:0]        s_tuser  = CMD_NONE;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    cursor_linked_list_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the engine's list state.
    logic [NUM_W-1:0]  shadow_number [SLOTS];
    logic [NA_W-1:0]   shadow_name_a [SLOTS];
    logic [NB_W-1:0]   shadow_name_b [SLOTS];
    logic [NC_W-1:0]   shadow_name_c [SLOTS];
    logic [LINK_W-1:0] shadow_link   [SLOTS];
    logic [LINK_W-1:0] shadow_head = NULL_LINK;
    int                slots_taken = 0;

    result_word_t expected_words [$];
    result_word_t oldest_word;
    int           error_count   = 0;
    int           cycle_count   = 0;
    bit           idle_on       = 1'b1;
    int           hold_requests = 0;
    int           hold_seen     = 0;
    int           hold_left     = 0;
    int           ready_gap     = 0;

    // Runaway guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Most gaps are zero or short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit slot_live(logic [LINK_W-1:0] link);
        return int'(link) < SLOTS && int'(link) < slots_taken;
    endfunction

    // Applies one accepted command to the shadow list and queues its results.
    task automatic apply_list_command(cmd_t cmd, logic [IDX_W-1:0] idx,
                                      logic [NUM_W-1:0] num, logic [NA_W-1:0] na,
                                      logic [NB_W-1:0] nb, logic [NC_W-1:0] nc);
        result_word_t w;
        int           p;
        int           s;
        int           steps;
        int           k;
        bit           at_end;
        logic [LINK_W-1:0] nx;
        w = '{ST_OK, '0, '0, '0, '0, '0, 1'b1};
        case (cmd)
            CMD_APPEND, CMD_INSERT:
            begin
                if (slots_taken >= SLOTS)
                    w.status = ST_FULL;
                else if (cmd == CMD_INSERT && !slot_live(LINK_W'(idx)))
                begin
                    w.status = ST_UNALLOC;
                    w.slot   = idx;
                end
                else
                begin
                    s = slots_taken;
                    if (cmd == CMD_INSERT)
                    begin
                        shadow_link[s]   = shadow_link[idx];
                        shadow_link[idx] = LINK_W'(s);
                    end
                    else if (!slot_live(shadow_head))
                    begin
                        shadow_link[s] = NULL_LINK;
                        shadow_head    = LINK_W'(s);
                    end
                    else
                    begin
                        // Walk to the tail; the new slot is not yet counted as live.
                        p     = shadow_head;
                        steps = 1;
                        while (steps < SLOTS && slot_live(shadow_link[p]))
                        begin
                            p = shadow_link[p];
                            steps++;
                        end
                        shadow_link[s] = NULL_LINK;
                        shadow_link[p] = LINK_W'(s);
                    end
                    shadow_number[s] = num;
                    shadow_name_a[s] = na;
                    shadow_name_b[s] = nb;
                    shadow_name_c[s] = nc;
                    slots_taken      = s + 1;
                    w.slot           = IDX_W'(s);
                end
                expected_words.push_back(w);
            end
            CMD_TRAVERSE:
            begin
                if (!slot_live(shadow_head))
                begin
                    w.status = ST_EMPTY;
                    expected_words.push_back(w);
                end
                else
                begin
                    p      = shadow_head;
                    k      = 0;
                    at_end = 1'b0;
                    while (!at_end)
                    begin
                        nx       = shadow_link[p];
                        at_end   = (k + 1 >= SLOTS) || !slot_live(nx);
                        w.slot   = IDX_W'(p);
                        w.number = shadow_number[p];
                        w.name_a = shadow_name_a[p];
                        w.name_b = shadow_name_b[p];
                        w.name_c = shadow_name_c[p];
                        w.last   = at_end;
                        expected_words.push_back(w);
                        k++;
                        p = nx;
                    end
                end
            end
            default:
                ; // The unused code is dropped without an answer.
        endcase
    endtask

    // Offers one command word after a random gap and waits for the handshake.
    task automatic send_command(cmd_t cmd, logic [IDX_W-1:0] idx,
                                logic [NUM_W-1:0] num, logic [NA_W-1:0] na,
                                logic [NB_W-1:0] nb, logic [NC_W-1:0] nc);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, nc, nb, na, num, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_list_command(cmd, idx, num, na, nb, nc);
    endtask

    task automatic send_random_data(cmd_t cmd, logic [IDX_W-1:0] idx);
        send_command(cmd, idx, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                     $urandom);
    endtask

    // Drops tvalid, then waits until every expected word has come.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            error_count++;
        end
    endtask

    // Result side: checks accepted words and drives tready with gaps and holds.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: status %0d slot %0d", m_tuser,
                           m_tdata[IDX_W-1:0]);
                    error_count++;
                end
                else
                begin
                    oldest_word = expected_words.pop_front();
                    check_field("status", oldest_word.status, m_tuser);
                    check_field("record_slot", oldest_word.slot, m_tdata[IDX_W-1:0]);
                    check_field("record_number", oldest_word.number,
                                m_tdata[NUM_LO +: NUM_W]);
                    check_field("record_name_a", oldest_word.name_a,
                                m_tdata[NA_LO +: NA_W]);
                    check_field("record_name_b", oldest_word.name_b,
                                m_tdata[NB_LO +: NB_W]);
                    check_field("record_name_c", oldest_word.name_c,
                                m_tdata[NC_LO +: NC_W]);
                    check_field("last", oldest_word.last, m_tlast);
                end
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                ready_gap = pick_gap();
                m_tready <= (ready_gap == 0);
                if (ready_gap > 0)
                    ready_gap--;
            end
        end
    end

    // Traverse and insert on an empty store, plus the unused code.
    task automatic test_empty_list();
        send_random_data(CMD_TRAVERSE, 6'd0);
        send_random_data(CMD_INSERT, 6'd0);
        send_random_data(CMD_INSERT, 6'd63);
        send_command(CMD_NONE, '1, '1, '1, '1, '1);
    endtask

    // Field extremes, head/middle/tail insertion and the allocation boundary.
    task automatic test_append_insert();
        send_command(CMD_APPEND, 6'd0, 32'h8000_0000, '1, '1, '1);
        send_command(CMD_APPEND, 6'd63, 32'h7FFF_FFFF, '0, '0, '0);
        send_command(CMD_INSERT, 6'd0, 32'hFFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0,
                     64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF);
        send_command(CMD_INSERT, 6'd1, 32'd0, 64'h5A5A_A5A5_F0F0_0F0F,
                     64'hFEDC_BA98_7654_3210, 32'h2152_4110);
        send_random_data(CMD_INSERT, 6'd4);
        send_random_data(CMD_APPEND, 6'd0);
        send_random_data(CMD_INSERT, 6'd3);
        send_random_data(CMD_TRAVERSE, '1);
        send_command(CMD_NONE, '0, '0, '0, '0, '0);
        wait_for_drain();
    endtask

    // The result side stops for a long stretch while commands keep coming, so
    // the engine's output register fills and tready on the command side drops.
    task automatic test_output_stall();
        int n;
        idle_on = 1'b0;
        hold_requests <= hold_requests + 1;
        for (n = 0; n < 10; n++)
        begin
            if (n % 3 == 0)
                send_random_data(CMD_TRAVERSE, 6'($urandom));
            else
                send_random_data(CMD_APPEND, 6'($urandom));
        end
        idle_on = 1'b1;
        wait_for_drain();
    endtask

    // Mostly well-formed appends and inserts until the store fills, then
    // traversals of the full list and store-full answers.
    task automatic test_random_mix(int count);
        int   n;
        int   r;
        cmd_t cmd;
        logic [IDX_W-1:0] idx;
        for (n = 0; n < count; n++)
        begin
            // Every third stretch of forty commands runs without idling.
            if (n % 40 == 0)
                idle_on = ((n / 40) % 3 != 2);
            if (n == count / 2)
                wait_for_drain();
            r   = $urandom_range(0, 99);
            idx = 6'($urandom);
            if (slots_taken < SLOTS)
            begin
                if (r < 45)
                    cmd = CMD_APPEND;
                else if (r < 80)
                begin
                    cmd = CMD_INSERT;
                    if (slots_taken > 0)
                        idx = 6'($urandom_range(0, slots_taken - 1));
                end
                else if (r < 88)
                    cmd = CMD_INSERT;
                else if (r < 97)
                    cmd = CMD_TRAVERSE;
                else
                    cmd = CMD_NONE;
            end
            else
            begin
                if (r < 35)
                    cmd = CMD_TRAVERSE;
                else if (r < 60)
                    cmd = CMD_APPEND;
                else if (r < 90)
                    cmd = CMD_INSERT;
                else
                    cmd = CMD_NONE;
            end
            send_random_data(cmd, idx);
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_append_insert();
        test_output_stall();
        test_random_mix(RANDOM_CMDS);

        wait_for_drain();
        // An ignored command may still be in flight; give the walk time to end.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule : cursor_linked_list_engine_top_tb

/* sim.f */
design/cll_pkg.sv
design/cll_ram.sv
design/cursor_linked_list_engine_top.sv
tb/cursor_linked_list_engine_top_tb.sv
